/* design/jsr_pkg.sv */
// Shared constants and types for the five-point Jacobi relaxation block.
// Used by the channel interfaces, the arithmetic pipeline and the top level.
// Depends on nothing.
package jsr_pkg;

  // Line store depth and the derived column index width.
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);

  // Widths fixed by the register and word fields.
  localparam int unsigned WIDTH_W   = 11;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned SUM_W     = VAL_W + 2;
  localparam int unsigned RES_W     = 64;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  // One line store entry holds a column of the two rows above.
  typedef struct packed {
    logic [VAL_W-1:0] two_above;
    logic [VAL_W-1:0] above;
  } line_entry_t;

  // Position and control that travel alongside a point through the pipeline.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
    logic             fresh;
  } point_meta_t;

  // Operands of one interior point; the right neighbour is passed in separately.
  typedef struct packed {
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] up;
    logic [VAL_W-1:0] center;
    logic [VAL_W-1:0] down;
    point_meta_t      meta;
  } point_op_t;

endpackage

/* design/jsr_if.sv */
// Valid/ready channel interfaces for grid samples in and relaxed points out.
// Depends on jsr_pkg.
interface jsr_in_if import jsr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] grid_value;

  modport source (output valid, output grid_value, input ready);
  modport sink (input valid, input grid_value, output ready);
endinterface

interface jsr_out_if import jsr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] new_value;
  logic [ROW_W-1:0]        point_row;
  logic [COL_W-1:0]        point_col;
  logic [RES_W-1:0]        residual_sum;
  logic                    last;

  modport source (output valid, output new_value, output point_row, output point_col,
                  output residual_sum, output last, input ready);
  modport sink (input valid, input new_value, input point_row, input point_col,
                input residual_sum, input last, output ready);
endinterface

/* design/jsr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module jsr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/jsr_pipe.sv */
// Arithmetic pipeline: four-neighbour average, squared difference and the
// saturating residual accumulator, ending in the output register.
// Depends on jsr_pkg and jsr_if.
module jsr_pipe import jsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             op_valid_i,
  input  point_op_t        op_i,
  input  logic [VAL_W-1:0] right_i,
  output logic             op_ready_o,
  jsr_out_if.source        out_o
);

  point_op_t        s1_q;
  logic             s1_v_q;
  logic [VAL_W-1:0] s2_nv_q, s2_center_q;
  point_meta_t      s2_meta_q;
  logic             s2_v_q;
  logic [VAL_W-1:0] s3_nv_q, s3_mag_q;
  point_meta_t      s3_meta_q;
  logic             s3_v_q;
  logic [VAL_W-1:0] s4_nv_q;
  logic [RES_W-1:0] s4_sq_q;
  point_meta_t      s4_meta_q;
  logic             s4_v_q;
  logic             out_v_q;
  logic [VAL_W-1:0] out_nv_q;
  logic [RES_W-1:0] out_res_q;
  point_meta_t      out_meta_q;
  logic [RES_W-1:0] acc_q, acc_d;

  logic             out_free, s4_free, s3_free, s2_free, s1_free;
  logic [SUM_W-1:0] sum;
  logic [VAL_W-1:0] nv;
  logic [VAL_W:0]   diff;
  logic [VAL_W-1:0] mag;
  logic [RES_W-1:0] sq;
  logic [RES_W-1:0] acc_base;
  logic [RES_W:0]   acc_sum;

  // A stage may load when it is empty or its word moves on in the same cycle.
  assign out_free   = !out_v_q || out_o.ready;
  assign s4_free    = !s4_v_q || out_free;
  assign s3_free    = !s3_v_q || s4_free;
  assign s2_free    = !s2_v_q || s3_free;
  assign s1_free    = !s1_v_q || s2_free;
  assign op_ready_o = s1_free;

  // The sum of four 32-bit values is exact in 34 bits; the arithmetic shift floors.
  assign sum = {{2{s1_q.left[VAL_W-1]}}, s1_q.left} + {{2{right_i[VAL_W-1]}}, right_i}
             + {{2{s1_q.up[VAL_W-1]}}, s1_q.up} + {{2{s1_q.down[VAL_W-1]}}, s1_q.down};
  assign nv  = sum[SUM_W-1:2];

  // Both operands lie in the 32-bit signed range, so the magnitude fits 32 bits.
  assign diff = {s2_nv_q[VAL_W-1], s2_nv_q} - {s2_center_q[VAL_W-1], s2_center_q};
  assign mag  = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];

  assign sq = {{(RES_W-VAL_W){1'b0}}, s3_mag_q} * {{(RES_W-VAL_W){1'b0}}, s3_mag_q};

  assign acc_base = s4_meta_q.fresh ? '0 : acc_q;
  assign acc_sum  = {1'b0, acc_base} + {1'b0, s4_sq_q};
  assign acc_d    = acc_sum[RES_W] ? '1 : acc_sum[RES_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      if (s1_free) s1_v_q <= op_valid_i;
      if (s2_free) s2_v_q <= s1_v_q;
      if (s3_free) s3_v_q <= s2_v_q;
      if (s4_free) s4_v_q <= s3_v_q;
      if (out_free) out_v_q <= s4_v_q;
      if (s4_v_q && out_free) acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && op_valid_i) begin
      s1_q <= op_i;
    end
    if (s2_free && s1_v_q) begin
      s2_nv_q     <= nv;
      s2_center_q <= s1_q.center;
      s2_meta_q   <= s1_q.meta;
    end
    if (s3_free && s2_v_q) begin
      s3_nv_q   <= s2_nv_q;
      s3_mag_q  <= mag;
      s3_meta_q <= s2_meta_q;
    end
    if (s4_free && s3_v_q) begin
      s4_nv_q   <= s3_nv_q;
      s4_sq_q   <= sq;
      s4_meta_q <= s3_meta_q;
    end
    if (out_free && s4_v_q) begin
      out_nv_q   <= s4_nv_q;
      out_res_q  <= acc_d;
      out_meta_q <= s4_meta_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.new_value    = out_nv_q;
  assign out_o.point_row    = out_meta_q.row;
  assign out_o.point_col    = out_meta_q.col;
  assign out_o.residual_sum = out_res_q;
  assign out_o.last         = out_meta_q.last;

endmodule

/* design/jacobi_stencil_relaxation.sv */
// Five-point Jacobi relaxation over a grid streamed in raster order. The block
// takes one sample per cycle while input ready is high and, for every interior
// point, gives its relaxed value, its position and the running squared residual
// after the sample below it was taken, through stages s1 to s4 and the output
// register. The two rows above live as one 64-bit word per column in a single
// line store; its one read port fetches the next column ahead while the current
// column is written back, allowing that rate. Input ready is low after reset and
// after each configuration write, while the read-ahead is redone for new sizes.
// Depends on jsr_pkg, jsr_if, jsr_ram and jsr_pipe.
module jacobi_stencil_relaxation import jsr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  jsr_in_if.sink               in_i,
  jsr_out_if.source            out_o
);

  logic [WIDTH_W-1:0] width_q;
  logic [ROW_W-1:0]   height_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               fresh_q, fresh_d;
  logic               stale_q;
  logic [VAL_W-1:0]   left_q;

  logic [WIDTH_W-1:0] wc;
  logic [ROW_W-1:0]   hc;
  logic               col_wrap, row_wrap, cn_wrap, rn_wrap;
  logic [ROW_W:0]     rp, rn;
  logic [WIDTH_W-1:0] cn;
  logic [COL_W-1:0]   c;
  logic [ROW_W-1:0]   r;
  logic               emit, is_last, fire, op_ready;
  line_entry_t        rd_entry, wr_entry;
  logic [COL_W-1:0]   ram_raddr;
  point_op_t          op;

  // Sizes as the counters see them.
  assign wc = (width_q < WIDTH_W'(3)) ? WIDTH_W'(3) :
              (width_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_q;
  assign hc = (height_q < ROW_W'(3)) ? ROW_W'(3) : height_q;

  // Position of the next sample, after any wrap caused by a change of size.
  assign col_wrap = {1'b0, col_q} >= wc;
  assign c        = col_wrap ? '0 : col_q;
  assign rp       = col_wrap ? {1'b0, row_q} + (ROW_W+1)'(1) : {1'b0, row_q};
  assign row_wrap = rp >= {1'b0, hc};
  assign r        = row_wrap ? '0 : rp[ROW_W-1:0];

  assign emit    = (r >= ROW_W'(2)) && (c != '0) && ({1'b0, c} <= wc - WIDTH_W'(2));
  assign is_last = (r == hc - ROW_W'(1)) && ({1'b0, c} == wc - WIDTH_W'(2));

  assign cn      = {1'b0, c} + WIDTH_W'(1);
  assign cn_wrap = cn >= wc;
  assign rn      = {1'b0, r} + (ROW_W+1)'(1);
  assign rn_wrap = rn >= {1'b0, hc};
  assign col_d   = cn_wrap ? '0 : cn[COL_W-1:0];
  assign row_d   = cn_wrap ? (rn_wrap ? '0 : rn[ROW_W-1:0]) : r;

  // The residual restarts whenever the row counter has passed through zero.
  assign fresh_d = (r == '0) ? 1'b1 : (emit ? 1'b0 : fresh_q);

  assign in_i.ready = op_ready && !stale_q;
  assign fire       = in_i.valid && in_i.ready;

  // The read port holds the entry of the column the next sample will use, once the read-ahead is redone.
  assign ram_raddr = fire ? col_d : c;
  assign wr_entry  = '{two_above: rd_entry.above, above: in_i.grid_value};

  jsr_ram #(
    .WIDTH ($bits(line_entry_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (c),
    .wdata_i (wr_entry),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  always_comb begin
    op.left       = left_q;
    op.up         = rd_entry.two_above;
    op.center     = rd_entry.above;
    op.down       = in_i.grid_value;
    op.meta.row   = r - ROW_W'(1);
    op.meta.col   = c;
    op.meta.last  = is_last;
    op.meta.fresh = fresh_q;
  end

  jsr_pipe u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (fire && emit),
    .op_i       (op),
    .right_i    (rd_entry.above),
    .op_ready_o (op_ready),
    .out_o      (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(1024);
      height_q <= ROW_W'(1024);
      col_q    <= '0;
      row_q    <= '0;
      fresh_q  <= 1'b1;
      stale_q  <= 1'b1;
    end else begin
      stale_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
          CFG_GRID_HEIGHT: height_q <= cfg_data_i[ROW_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        col_q   <= col_d;
        row_q   <= row_d;
        fresh_q <= fresh_d;
      end
    end
  end

  // The centre of this column is the left neighbour of the next one.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      left_q <= rd_entry.above;
    end
  end

  a_no_same_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (ram_raddr != c))
    else $error("line store read and write hit the same column");

  a_cfg_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_i.ready)
    else $error("sample taken before the read-ahead was redone");

  a_interior_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.point_row != '0 && out_o.point_col != '0))
    else $error("boundary point emitted");

endmodule
